// ===== rtl/spd_pkg.sv =====
package spd_pkg;

   // Default payload store depth in bytes.
   localparam int MAX_PAYLOAD_DEF = 64;

   // Fixed field widths.
   localparam int LEN_W   = 16;
   localparam int FILL_W  = 7;
   localparam int INDEX_W = 6;
   localparam int CSR_IDX_W = 1;

   // Marker register reset values.
   localparam logic [7:0] START_MARKER_RST = 8'h02;
   localparam logic [7:0] STOP_MARKER_RST  = 8'h03;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_START_MARKER = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_MARKER  = 1'b1;

   // Request op codes.
   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_OVERRUN = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_GOOD    = 2'd0,
      STATUS_LENGTH  = 2'd1,
      STATUS_CHECK   = 2'd2,
      STATUS_OVERRUN = 2'd3
   } status_type;

   // Selects what the output register is loaded with.
   typedef enum logic [1:0] {
      OUT_ERROR = 2'd0,
      OUT_EMPTY = 2'd1,
      OUT_DATA  = 2'd2
   } out_sel_type;

   // Frame parser and emitter states.
   typedef enum logic [3:0] {
      ST_WAIT,
      ST_LEN_LO,
      ST_LEN_HI,
      ST_KIND,
      ST_DATA,
      ST_SUM,
      ST_STOP,
      ST_EMIT_RD,
      ST_EMIT_WR
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        clear_frame;
      logic        load_len_lo;
      logic        load_len_hi;
      logic        load_kind;
      logic        store_byte;
      logic        load_sum;
      logic        rd_start;
      logic        rd_issue;
      logic        rd_advance;
      logic        out_load;
      out_sel_type out_sel;
      status_type  out_status;
   } spd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic start_hit;
      logic len_too_long;
      logic len_zero;
      logic fill_done;
      logic frame_ok;
      logic rd_last;
      logic out_free;
   } spd_stat_type;

endpackage

// ===== rtl/spd_req_if.sv =====
interface spd_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_data;

   modport source (output valid, output op, output rx_data, input ready);
   modport sink (input valid, input op, input rx_data, output ready);
endinterface

// ===== rtl/spd_rsp_if.sv =====
interface spd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] msg_kind;
   logic [6:0] frame_length;
   logic [5:0] byte_index;
   logic [7:0] payload_byte;
   logic       has_byte;
   logic       last;

   modport source (output valid, output status, output msg_kind, output frame_length,
                   output byte_index, output payload_byte, output has_byte, output last,
                   input ready);
   modport sink (input valid, input status, input msg_kind, input frame_length,
                 input byte_index, input payload_byte, input has_byte, input last,
                 output ready);
endinterface

// ===== rtl/spd_ctrl.sv =====
module spd_ctrl import spd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_op,
   output logic         req_ready,
   input  spd_stat_type stat,
   output spd_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;
   logic      accept;
   logic      emitting;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // A request is taken only outside the emit loop and when the result slot can take a result.
   assign emitting  = (state_ff == ST_EMIT_RD) || (state_ff == ST_EMIT_WR);
   assign req_ready = !emitting && stat.out_free;
   assign accept    = req_valid && req_ready;

   // Next state and datapath commands.
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.out_sel    = OUT_ERROR;
      cmd.out_status = STATUS_GOOD;
      unique case (state_ff)
         ST_EMIT_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_DATA;
               if (stat.rd_last) begin
                  state_in = ST_WAIT;
               end else begin
                  cmd.rd_advance = 1'b1;
                  state_in       = ST_EMIT_RD;
               end
            end
         end
         default: begin
            if (accept && (req_op == OP_OVERRUN)) begin
               // An overrun drops any frame in progress.
               cmd.out_load   = 1'b1;
               cmd.out_status = STATUS_OVERRUN;
               state_in       = ST_WAIT;
            end else if (accept) begin
               unique case (state_ff)
                  ST_WAIT: begin
                     if (stat.start_hit) begin
                        cmd.clear_frame = 1'b1;
                        state_in        = ST_LEN_LO;
                     end
                  end
                  ST_LEN_LO: begin
                     cmd.load_len_lo = 1'b1;
                     state_in        = ST_LEN_HI;
                  end
                  ST_LEN_HI: begin
                     cmd.load_len_hi = 1'b1;
                     if (stat.len_too_long) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = STATUS_LENGTH;
                        state_in       = ST_WAIT;
                     end else begin
                        state_in = ST_KIND;
                     end
                  end
                  ST_KIND: begin
                     cmd.load_kind = 1'b1;
                     state_in      = stat.len_zero ? ST_SUM : ST_DATA;
                  end
                  ST_DATA: begin
                     cmd.store_byte = 1'b1;
                     if (stat.fill_done) begin
                        state_in = ST_SUM;
                     end
                  end
                  ST_SUM: begin
                     cmd.load_sum = 1'b1;
                     state_in     = ST_STOP;
                  end
                  ST_STOP: begin
                     if (!stat.frame_ok) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = STATUS_CHECK;
                        state_in       = ST_WAIT;
                     end else if (stat.len_zero) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_EMPTY;
                        state_in     = ST_WAIT;
                     end else begin
                        cmd.rd_start = 1'b1;
                        state_in     = ST_EMIT_RD;
                     end
                  end
                  default: begin
                     state_in = ST_WAIT;
                  end
               endcase
            end
         end
      endcase
   end

   // An overrun always sends the parser back to waiting for a start byte.
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == OP_OVERRUN)) |=> (state_ff == ST_WAIT))
      else $error("overrun did not return the parser to waiting");

   // Every memory read is followed by the emit write state, which hands its data to the result slot.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_RD) |=> (state_ff == ST_EMIT_WR))
      else $error("emit read not followed by emit write");

   // A pending result is never overwritten.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> stat.out_free)
      else $error("result slot loaded while still occupied");

endmodule

// ===== rtl/spd_datapath.sv =====
module spd_datapath import spd_pkg::*; #(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           rx_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata,
   input  spd_cmd_type          cmd,
   output spd_stat_type         stat,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [7:0]           rsp_msg_kind,
   output logic [6:0]           rsp_frame_length,
   output logic [5:0]           rsp_byte_index,
   output logic [7:0]           rsp_payload_byte,
   output logic                 rsp_has_byte,
   output logic                 rsp_last
);

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   // Marker registers.
   logic [7:0] start_marker_ff;
   logic [7:0] stop_marker_ff;

   // Frame state.
   logic [LEN_W-1:0]  expected_len_ff;
   logic [LEN_W-1:0]  expected_len_in;
   logic [FILL_W-1:0] fill_count_ff;
   logic [FILL_W-1:0] fill_count_in;
   logic [7:0]        kind_seen_ff;
   logic [7:0]        kind_seen_in;
   logic [7:0]        running_xor_ff;
   logic [7:0]        running_xor_in;
   logic [7:0]        xor_received_ff;
   logic [7:0]        xor_received_in;
   logic [LEN_W-1:0]  len_candidate;

   // Payload store and its read side.
   logic [7:0]    mem [MAX_PAYLOAD];
   logic [7:0]    mem_q_ff;
   logic [AW-1:0] rd_idx_ff;
   logic [AW-1:0] rd_idx_in;

   // Result slot.
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [1:0] status_ff;
   logic [1:0] status_in;
   logic [7:0] kind_ff;
   logic [7:0] kind_in;
   logic [6:0] len_ff;
   logic [6:0] len_in;
   logic [5:0] idx_ff;
   logic [5:0] idx_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       has_ff;
   logic       has_in;
   logic       last_ff;
   logic       last_in;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RST;
         stop_marker_ff  <= STOP_MARKER_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_MARKER: start_marker_ff <= csr_wdata;
            CSR_STOP_MARKER:  stop_marker_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Frame state updates; the checksum folds in length, type and payload bytes.
   assign len_candidate = {rx_data, expected_len_ff[7:0]};

   always_comb begin
      expected_len_in = expected_len_ff;
      fill_count_in   = fill_count_ff;
      kind_seen_in    = kind_seen_ff;
      running_xor_in  = running_xor_ff;
      xor_received_in = xor_received_ff;
      if (cmd.clear_frame) begin
         expected_len_in = '0;
         fill_count_in   = '0;
         kind_seen_in    = '0;
         running_xor_in  = '0;
         xor_received_in = '0;
      end
      if (cmd.load_len_lo) begin
         expected_len_in = {8'h00, rx_data};
      end
      if (cmd.load_len_hi) begin
         expected_len_in = len_candidate;
      end
      if (cmd.load_kind) begin
         kind_seen_in = rx_data;
      end
      if (cmd.store_byte) begin
         fill_count_in = fill_count_ff + 7'd1;
      end
      if (cmd.load_len_lo || cmd.load_len_hi || cmd.load_kind || cmd.store_byte) begin
         running_xor_in = running_xor_ff ^ rx_data;
      end
      if (cmd.load_sum) begin
         xor_received_in = rx_data;
      end
   end

   always_ff @(posedge clock) begin
      expected_len_ff <= expected_len_in;
      fill_count_ff   <= fill_count_in;
      kind_seen_ff    <= kind_seen_in;
      running_xor_ff  <= running_xor_in;
      xor_received_ff <= xor_received_in;
   end

   // Payload store: written during the frame, read one byte at a time while emitting.
   always_ff @(posedge clock) begin
      if (cmd.store_byte) begin
         mem[fill_count_ff[AW-1:0]] <= rx_data;
      end
      if (cmd.rd_issue) begin
         mem_q_ff <= mem[rd_idx_ff];
      end
   end

   // Emit read pointer.
   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (cmd.rd_start) begin
         rd_idx_in = '0;
      end else if (cmd.rd_advance) begin
         rd_idx_in = rd_idx_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
   end

   // Status to the controller.
   assign stat.start_hit    = (rx_data == start_marker_ff);
   assign stat.len_too_long = (len_candidate > LEN_W'(MAX_PAYLOAD));
   assign stat.len_zero     = (expected_len_ff == '0);
   assign stat.fill_done    = ({9'd0, fill_count_ff + 7'd1} >= expected_len_ff);
   assign stat.frame_ok     = (rx_data == stop_marker_ff) && (running_xor_ff == xor_received_ff);
   assign stat.rd_last      = (7'(rd_idx_ff) == (expected_len_ff[6:0] - 7'd1));
   assign stat.out_free     = !rsp_valid_ff || rsp_ready;

   // Result slot load.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      kind_in      = kind_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      byte_in      = byte_ff;
      has_in       = has_ff;
      last_in      = last_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         unique case (cmd.out_sel)
            OUT_EMPTY: begin
               status_in = STATUS_GOOD;
               kind_in   = kind_seen_ff;
               len_in    = '0;
               idx_in    = '0;
               byte_in   = '0;
               has_in    = 1'b0;
               last_in   = 1'b1;
            end
            OUT_DATA: begin
               status_in = STATUS_GOOD;
               kind_in   = kind_seen_ff;
               len_in    = expected_len_ff[6:0];
               idx_in    = INDEX_W'(rd_idx_ff);
               byte_in   = mem_q_ff;
               has_in    = 1'b1;
               last_in   = stat.rd_last;
            end
            default: begin
               status_in = cmd.out_status;
               kind_in   = '0;
               len_in    = '0;
               idx_in    = '0;
               byte_in   = '0;
               has_in    = 1'b0;
               last_in   = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      kind_ff   <= kind_in;
      len_ff    <= len_in;
      idx_ff    <= idx_in;
      byte_ff   <= byte_in;
      has_ff    <= has_in;
      last_ff   <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_msg_kind     = kind_ff;
   assign rsp_frame_length = len_ff;
   assign rsp_byte_index   = idx_ff;
   assign rsp_payload_byte = byte_ff;
   assign rsp_has_byte     = has_ff;
   assign rsp_last         = last_ff;

   // Payload bytes are stored only below the store depth.
   assert property (@(posedge clock) disable iff (reset)
      cmd.store_byte |-> (fill_count_ff < FILL_W'(MAX_PAYLOAD)))
      else $error("payload store written past its depth");

   // A payload result always refers to a byte inside the received length.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && (cmd.out_sel == OUT_DATA))
         |-> ((LEN_W'(rd_idx_ff) < expected_len_ff)
              && (expected_len_ff <= LEN_W'(MAX_PAYLOAD))))
      else $error("payload result outside the frame length");

endmodule

// ===== rtl/serial_packet_deframer.sv =====
// Channel   Direction  Handshake      Payload
// req_chan  in         valid/ready    op, rx_data
// rsp_chan  out        valid/ready    status, msg_kind, frame_length, byte_index,
//                                     payload_byte, has_byte, last
// csr_*     in         write enable   csr_index, csr_wdata
//
// One request is taken per cycle while a frame is being parsed and the result register can
// load; error and empty-frame results leave in the cycle after the request that ends them.
// A good frame of n payload bytes is sent as n results, each made by a memory read and then
// a load of the result register; requests are held off until the last of them is loaded.
// Reset is synchronous and puts the parser in the waiting state with markers 2 and 3.
// A stalled result holds the result register; requests are taken only while it can load.
module serial_packet_deframer import spd_pkg::*; #(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   spd_req_if.sink              req_chan,
   spd_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   spd_cmd_type  cmd;
   spd_stat_type stat;

   // Frame sequencing.
   spd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Frame registers, payload store and result register.
   spd_datapath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .rx_data          (req_chan.rx_data),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_status       (rsp_chan.status),
      .rsp_msg_kind     (rsp_chan.msg_kind),
      .rsp_frame_length (rsp_chan.frame_length),
      .rsp_byte_index   (rsp_chan.byte_index),
      .rsp_payload_byte (rsp_chan.payload_byte),
      .rsp_has_byte     (rsp_chan.has_byte),
      .rsp_last         (rsp_chan.last)
   );

endmodule
